// ===== rtl/ncpr_pkg.sv =====
package ncpr_pkg;

	localparam int CELL_COUNT = 16;
	localparam int CELL_W = 4;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int PC_W = ADDR_W + 1;
	localparam int CNT_W = ADDR_W + 1;
	localparam int STEP_W = 16;
	localparam int IMG_W = CELL_COUNT * CELL_W;
	localparam int OUT_W = 96;
	localparam int OUT_PAD_W = OUT_W - IMG_W - 2 * CELL_W - 2 - STEP_W;
	localparam logic [STEP_W-1:0] LIMIT_RESET = 16'd2000;

	typedef enum logic [3:0] {
		OP_HALT,
		OP_ADD,
		OP_SUB,
		OP_INC0,
		OP_INC1,
		OP_DEC0,
		OP_DEC1,
		OP_SWAP,
		OP_XOR,
		OP_LD0,
		OP_LD1,
		OP_ST0,
		OP_ST1,
		OP_JMP,
		OP_JZ,
		OP_JNZ
	} op_t;

	typedef enum logic [1:0] {
		CAUSE_HALT,
		CAUSE_PAST,
		CAUSE_LIMIT
	} cause_t;

	typedef enum logic [1:0] {
		ADDR_CNT,
		ADDR_PC,
		ADDR_PC1,
		ADDR_RD
	} addr_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_FETCH,
		ST_OPC,
		ST_OPND,
		ST_LDW,
		ST_DUMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      start;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      img_shift;
		logic      img_from_rd;
		logic      load_we;
		logic      ram_re;
		addr_sel_t addr_sel;
		logic      op_capture;
		logic      exec_one;
		logic      exec_two;
		logic      exec_ld;
		logic      cause_we;
		cause_t    cause;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic pc_out;
		op_t  op_now;
		op_t  op_q;
		logic limit_hit;
		logic cnt_last;
		logic cnt_end;
		logic cnt_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/ncpr_ram.sv =====
module ncpr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ncpr_ctrl.sv =====
module ncpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  ncpr_pkg::sts_t    sts,
	output ncpr_pkg::cmd_t    cmd
);

	ncpr_pkg::state_t state_q;
	ncpr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ncpr_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ncpr_pkg::ST_LOAD;
				end
			end
			ncpr_pkg::ST_LOAD: begin
				if (sts.cnt_last) begin
					state_d = ncpr_pkg::ST_FETCH;
				end
			end
			ncpr_pkg::ST_FETCH: begin
				if (sts.pc_out) begin
					state_d = ncpr_pkg::ST_DUMP;
				end else begin
					state_d = ncpr_pkg::ST_OPC;
				end
			end
			ncpr_pkg::ST_OPC: begin
				if (sts.op_now == ncpr_pkg::OP_HALT || sts.limit_hit) begin
					state_d = ncpr_pkg::ST_DUMP;
				end else if (sts.op_now inside {[ncpr_pkg::OP_ADD:ncpr_pkg::OP_SWAP]}) begin
					state_d = ncpr_pkg::ST_FETCH;
				end else begin
					state_d = ncpr_pkg::ST_OPND;
				end
			end
			ncpr_pkg::ST_OPND: begin
				if (sts.op_q inside {ncpr_pkg::OP_LD0, ncpr_pkg::OP_LD1}) begin
					state_d = ncpr_pkg::ST_LDW;
				end else begin
					state_d = ncpr_pkg::ST_FETCH;
				end
			end
			ncpr_pkg::ST_LDW: begin
				state_d = ncpr_pkg::ST_FETCH;
			end
			ncpr_pkg::ST_DUMP: begin
				if (sts.cnt_end) begin
					state_d = ncpr_pkg::ST_DONE;
				end
			end
			ncpr_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_d = ncpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ncpr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.addr_sel = ncpr_pkg::ADDR_CNT;
		cmd.cause = ncpr_pkg::CAUSE_HALT;
		s_axis_tready = 1'b0;
		case (state_q)
			ncpr_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.start = s_axis_tvalid;
			end
			ncpr_pkg::ST_LOAD: begin
				cmd.load_we = 1'b1;
				cmd.img_shift = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.cnt_clr = sts.cnt_last;
			end
			ncpr_pkg::ST_FETCH: begin
				if (sts.pc_out) begin
					cmd.cause_we = 1'b1;
					cmd.cause = ncpr_pkg::CAUSE_PAST;
					cmd.cnt_clr = 1'b1;
				end else begin
					cmd.ram_re = 1'b1;
					cmd.addr_sel = ncpr_pkg::ADDR_PC;
				end
			end
			ncpr_pkg::ST_OPC: begin
				cmd.op_capture = 1'b1;
				if (sts.op_now == ncpr_pkg::OP_HALT) begin
					cmd.cause_we = 1'b1;
					cmd.cause = ncpr_pkg::CAUSE_HALT;
					cmd.cnt_clr = 1'b1;
				end else if (sts.limit_hit) begin
					cmd.cause_we = 1'b1;
					cmd.cause = ncpr_pkg::CAUSE_LIMIT;
					cmd.cnt_clr = 1'b1;
				end else if (sts.op_now inside {[ncpr_pkg::OP_ADD:ncpr_pkg::OP_SWAP]}) begin
					cmd.exec_one = 1'b1;
				end else begin
					cmd.ram_re = 1'b1;
					cmd.addr_sel = ncpr_pkg::ADDR_PC1;
				end
			end
			ncpr_pkg::ST_OPND: begin
				if (sts.op_q inside {ncpr_pkg::OP_LD0, ncpr_pkg::OP_LD1}) begin
					cmd.ram_re = 1'b1;
					cmd.addr_sel = ncpr_pkg::ADDR_RD;
				end else begin
					cmd.exec_two = 1'b1;
				end
			end
			ncpr_pkg::ST_LDW: begin
				cmd.exec_ld = 1'b1;
			end
			ncpr_pkg::ST_DUMP: begin
				cmd.ram_re = !sts.cnt_end;
				cmd.addr_sel = ncpr_pkg::ADDR_CNT;
				cmd.img_shift = !sts.cnt_zero;
				cmd.img_from_rd = 1'b1;
				cmd.cnt_inc = !sts.cnt_end;
			end
			ncpr_pkg::ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/ncpr_dp.sv =====
module ncpr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ncpr_pkg::IMG_W-1:0]    s_axis_tdata,
	input  logic                          cfg_we,
	input  logic [ncpr_pkg::STEP_W-1:0]   cfg_wdata,
	input  ncpr_pkg::cmd_t                cmd,
	output ncpr_pkg::sts_t                sts,
	input  logic                          m_axis_tready,
	output logic                          m_axis_tvalid,
	output logic [ncpr_pkg::OUT_W-1:0]    m_axis_tdata
);

	logic [ncpr_pkg::STEP_W-1:0] limit_q;
	logic [ncpr_pkg::STEP_W-1:0] step_q;
	logic [ncpr_pkg::PC_W-1:0]   pc_q;
	logic [ncpr_pkg::CELL_W-1:0] r0_q;
	logic [ncpr_pkg::CELL_W-1:0] r1_q;
	logic [ncpr_pkg::IMG_W-1:0]  img_q;
	logic [ncpr_pkg::CNT_W-1:0]  cnt_q;
	ncpr_pkg::op_t               op_q;
	ncpr_pkg::cause_t            cause_q;
	logic                        out_valid_q;
	logic [ncpr_pkg::OUT_W-1:0]  out_data_q;

	logic [ncpr_pkg::CELL_W-1:0] rd_data;
	logic                        ram_we;
	logic [ncpr_pkg::ADDR_W-1:0] ram_waddr;
	logic [ncpr_pkg::CELL_W-1:0] ram_wdata;
	logic [ncpr_pkg::ADDR_W-1:0] ram_raddr;
	logic [ncpr_pkg::CELL_W-1:0] shift_nib;
	logic [ncpr_pkg::PC_W-1:0]   pc_d;
	logic [ncpr_pkg::CELL_W-1:0] r0_d;
	logic [ncpr_pkg::CELL_W-1:0] r1_d;
	logic [ncpr_pkg::PC_W-1:0]   d_ext;
	logic                        is_store;
	logic                        out_free;

	assign d_ext = {1'b0, rd_data};
	assign is_store = (op_q == ncpr_pkg::OP_ST0) || (op_q == ncpr_pkg::OP_ST1);
	assign ram_we = cmd.load_we || (cmd.exec_two && is_store);
	assign ram_waddr = cmd.exec_two ? rd_data : cnt_q[ncpr_pkg::ADDR_W-1:0];
	assign ram_wdata = cmd.exec_two ? ((op_q == ncpr_pkg::OP_ST0) ? r0_q : r1_q)
		: img_q[ncpr_pkg::CELL_W-1:0];
	assign shift_nib = cmd.img_from_rd ? rd_data : '0;
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		case (cmd.addr_sel)
			ncpr_pkg::ADDR_CNT: ram_raddr = cnt_q[ncpr_pkg::ADDR_W-1:0];
			ncpr_pkg::ADDR_PC:  ram_raddr = pc_q[ncpr_pkg::ADDR_W-1:0];
			ncpr_pkg::ADDR_PC1: ram_raddr = pc_q[ncpr_pkg::ADDR_W-1:0] + 1'b1;
			ncpr_pkg::ADDR_RD:  ram_raddr = rd_data;
			default:            ram_raddr = cnt_q[ncpr_pkg::ADDR_W-1:0];
		endcase
	end

	ncpr_ram #(
		.WIDTH(ncpr_pkg::CELL_W),
		.DEPTH(ncpr_pkg::CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_comb begin
		pc_d = pc_q;
		r0_d = r0_q;
		r1_d = r1_q;
		if (cmd.exec_one) begin
			pc_d = pc_q + 1'b1;
			case (ncpr_pkg::op_t'(rd_data))
				ncpr_pkg::OP_ADD:  r0_d = r0_q + r1_q;
				ncpr_pkg::OP_SUB:  r0_d = r0_q - r1_q;
				ncpr_pkg::OP_INC0: r0_d = r0_q + 1'b1;
				ncpr_pkg::OP_INC1: r1_d = r1_q + 1'b1;
				ncpr_pkg::OP_DEC0: r0_d = r0_q - 1'b1;
				ncpr_pkg::OP_DEC1: r1_d = r1_q - 1'b1;
				ncpr_pkg::OP_SWAP: begin
					r0_d = r1_q;
					r1_d = r0_q;
				end
				default: ;
			endcase
		end else if (cmd.exec_two) begin
			pc_d = pc_q + 2'd2;
			case (op_q)
				ncpr_pkg::OP_XOR: r0_d = r0_q ^ rd_data;
				ncpr_pkg::OP_JMP: pc_d = d_ext;
				ncpr_pkg::OP_JZ: begin
					if (r0_q == '0) begin
						pc_d = d_ext;
					end
				end
				ncpr_pkg::OP_JNZ: begin
					if (r0_q != '0) begin
						pc_d = d_ext;
					end
				end
				default: ;
			endcase
		end else if (cmd.exec_ld) begin
			pc_d = pc_q + 2'd2;
			if (op_q == ncpr_pkg::OP_LD0) begin
				r0_d = rd_data;
			end else begin
				r1_d = rd_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ncpr_pkg::LIMIT_RESET;
			step_q <= '0;
			pc_q <= '0;
			r0_q <= '0;
			r1_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.start) begin
				step_q <= ncpr_pkg::STEP_W'(1);
				pc_q <= '0;
				r0_q <= '0;
				r1_q <= '0;
			end else begin
				pc_q <= pc_d;
				r0_q <= r0_d;
				r1_q <= r1_d;
				if (cmd.exec_one || cmd.exec_two || cmd.exec_ld) begin
					step_q <= step_q + 1'b1;
				end
			end
			if (cmd.start || cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			img_q <= s_axis_tdata;
		end else if (cmd.img_shift) begin
			img_q <= {shift_nib, img_q[ncpr_pkg::IMG_W-1:ncpr_pkg::CELL_W]};
		end
		if (cmd.op_capture) begin
			op_q <= ncpr_pkg::op_t'(rd_data);
		end
		if (cmd.cause_we) begin
			cause_q <= cmd.cause;
		end
		if (cmd.out_load) begin
			out_data_q <= {{ncpr_pkg::OUT_PAD_W{1'b0}}, img_q, r1_q, r0_q, cause_q, step_q};
		end
	end

	assign sts.pc_out = pc_q[ncpr_pkg::PC_W-1];
	assign sts.op_now = ncpr_pkg::op_t'(rd_data);
	assign sts.op_q = op_q;
	assign sts.limit_hit = step_q >= limit_q;
	assign sts.cnt_last = cnt_q == ncpr_pkg::CNT_W'(ncpr_pkg::CELL_COUNT - 1);
	assign sts.cnt_end = cnt_q == ncpr_pkg::CNT_W'(ncpr_pkg::CELL_COUNT);
	assign sts.cnt_zero = cnt_q == '0;
	assign sts.out_free = out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

// ===== rtl/nibble_cpu_program_runner_core.sv =====
// Runs one program on a small 4-bit machine with two registers and sixteen
// 4-bit memory cells. Each input beat on the s_axis channel carries a 64-bit
// program image, cell 0 in bits 3:0. The block loads the image into its cell
// memory, clears both registers and the program counter, and executes until a
// HALT opcode, the program counter running past the last cell, or the step
// count reaching cycle_limit. One output beat on m_axis then carries the step
// count, the stop cause, both registers and the final memory image.
// The image is first written into the cell memory. Each instruction reads
// its opcode, xor, store and jump then an operand, and a load its operand
// and the addressed cell, all through the memory's single read port. After a
// stop the memory is read back out and the output register filled; only then
// is the next image accepted. The user writes cycle_limit through cfg_we and
// cfg_wdata only while no program runs; the block does not enforce this.
// Reset sets cycle_limit to 2000, empties the output register and returns
// the block to idle. A finished result waits in the output register while
// the receiver stalls, and the block already accepts and runs the next
// image; it holds that second result until the register is free.
module nibble_cpu_program_runner_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// program_image[63:0]
	input  logic [ncpr_pkg::IMG_W-1:0]    s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// cycle_count[15:0], stop_cause[17:16], final_r0[21:18], final_r1[25:22],
	// final_memory[89:26], zeros[95:90]
	output logic [ncpr_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                          cfg_we,
	input  logic [ncpr_pkg::STEP_W-1:0]   cfg_wdata
);

	ncpr_pkg::cmd_t cmd;
	ncpr_pkg::sts_t sts;

	ncpr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	ncpr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== rtl/ncpr_chk.sv =====
module ncpr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [ncpr_pkg::OUT_W-1:0]    m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Output beat changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Input accepted while a program was loading.");

	a_cause_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3)
		else $error("Stop cause out of range.");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:0] != 16'd0)
		else $error("Cycle count of zero reported.");

	a_no_result_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("Result appeared right after an accepted image.");

endmodule

bind nibble_cpu_program_runner_core ncpr_chk u_ncpr_chk (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import ncpr_pkg::*;

	typedef struct {
		logic [STEP_W-1:0] steps;
		cause_t            cause;
		logic [CELL_W-1:0] r0;
		logic [CELL_W-1:0] r1;
		logic [IMG_W-1:0]  cells;
	} run_report_t;

	class run_checker;
		logic [STEP_W-1:0] cycle_limit = LIMIT_RESET;
		run_report_t       pending_reports[$];
		int                mismatches = 0;

		function run_report_t run_program(logic [IMG_W-1:0] image);
			logic [CELL_W-1:0] cells[CELL_COUNT];
			logic [CELL_W-1:0] r0, r1, opnd, swap_tmp;
			logic [PC_W-1:0]   pc;
			logic [STEP_W-1:0] steps;
			logic [ADDR_W-1:0] at;
			op_t               op;
			cause_t            why;
			bit                stopped;
			run_report_t       rep;
			for (int i = 0; i < CELL_COUNT; i++)
				cells[i] = image[CELL_W*i +: CELL_W];
			r0 = '0;
			r1 = '0;
			pc = '0;
			steps = 1;
			stopped = 0;
			while (!stopped) begin
				at = pc[ADDR_W-1:0];
				if (pc >= CELL_COUNT) begin
					why = CAUSE_PAST;
					stopped = 1;
				end else if (op_t'(cells[at]) == OP_HALT) begin
					why = CAUSE_HALT;
					stopped = 1;
				end else if (steps >= cycle_limit) begin
					why = CAUSE_LIMIT;
					stopped = 1;
				end else begin
					op = op_t'(cells[at]);
					opnd = cells[at + 1'b1];
					case (op)
						OP_ADD: begin r0 = r0 + r1; pc = pc + 1; end
						OP_SUB: begin r0 = r0 - r1; pc = pc + 1; end
						OP_INC0: begin r0 = r0 + 1; pc = pc + 1; end
						OP_INC1: begin r1 = r1 + 1; pc = pc + 1; end
						OP_DEC0: begin r0 = r0 - 1; pc = pc + 1; end
						OP_DEC1: begin r1 = r1 - 1; pc = pc + 1; end
						OP_SWAP: begin
							swap_tmp = r0;
							r0 = r1;
							r1 = swap_tmp;
							pc = pc + 1;
						end
						OP_XOR: begin r0 = r0 ^ opnd; pc = pc + 2; end
						OP_LD0: begin r0 = cells[opnd]; pc = pc + 2; end
						OP_LD1: begin r1 = cells[opnd]; pc = pc + 2; end
						OP_ST0: begin cells[opnd] = r0; pc = pc + 2; end
						OP_ST1: begin cells[opnd] = r1; pc = pc + 2; end
						OP_JMP: pc = {1'b0, opnd};
						OP_JZ: pc = (r0 == 0) ? {1'b0, opnd} : pc + 2;
						OP_JNZ: pc = (r0 != 0) ? {1'b0, opnd} : pc + 2;
						default: pc = pc + 1;
					endcase
					steps = steps + 1;
				end
			end
			rep.steps = steps;
			rep.cause = why;
			rep.r0 = r0;
			rep.r1 = r1;
			for (int i = 0; i < CELL_COUNT; i++)
				rep.cells[CELL_W*i +: CELL_W] = cells[i];
			return rep;
		endfunction

		function void note_image(logic [IMG_W-1:0] image);
			pending_reports.push_back(run_program(image));
		endfunction

		function void check_report(logic [OUT_W-1:0] beat);
			run_report_t want;
			if (pending_reports.size() == 0) begin
				$error("result beat %h arrived with no run outstanding", beat);
				mismatches++;
				return;
			end
			want = pending_reports.pop_front();
			if (beat[15:0] !== want.steps) begin
				$error("cycle_count expected %0d actual %0d", want.steps, beat[15:0]);
				mismatches++;
			end
			if (beat[17:16] !== want.cause) begin
				$error("stop_cause expected %0d actual %0d", want.cause, beat[17:16]);
				mismatches++;
			end
			if (beat[21:18] !== want.r0) begin
				$error("final_r0 expected %h actual %h", want.r0, beat[21:18]);
				mismatches++;
			end
			if (beat[25:22] !== want.r1) begin
				$error("final_r1 expected %h actual %h", want.r1, beat[25:22]);
				mismatches++;
			end
			if (beat[89:26] !== want.cells) begin
				$error("final_memory expected %h actual %h", want.cells, beat[89:26]);
				mismatches++;
			end
			if (beat[95:90] !== '0) begin
				$error("padding expected 0 actual %h", beat[95:90]);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IMG_W-1:0]     s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 cfg_we;
	logic [STEP_W-1:0]    cfg_wdata;

	run_checker checker_h;
	int         images_sent = 0;
	int         send_idle = 38;
	int         recv_idle = 72;
	bit         hold_request = 0;
	int         hold_left = 0;

	nibble_cpu_program_runner_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#36_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				checker_h.check_report(m_axis_tdata);
			if (hold_request) begin
				hold_request = 0;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_image(logic [IMG_W-1:0] image);
		if (images_sent < 97) begin
			send_idle = 38;
			recv_idle = 72;
		end else if (images_sent < 194) begin
			send_idle = 72;
			recv_idle = 38;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= image;
		do
			@(posedge clk);
		while (!s_axis_tready);
		checker_h.note_image(image);
		images_sent++;
	endtask

	task automatic drain_runs();
		s_axis_tvalid <= 1'b0;
		while (checker_h.pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_limit(logic [STEP_W-1:0] value);
		drain_runs();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		checker_h.cycle_limit = value;
	endtask

	function automatic logic [IMG_W-1:0] random_program();
		logic [IMG_W-1:0] image;
		image = {$urandom, $urandom};
		case ($urandom_range(3))
			0: ;
			1: image[CELL_W*$urandom_range(15) +: CELL_W] = OP_HALT;
			2: image[11:0] = {4'h0, OP_JNZ, OP_INC0};
			default: image[7:0] = {4'($urandom_range(15)), OP_JMP};
		endcase
		return image;
	endfunction

	task automatic send_random(int count);
		repeat (count) send_image(random_program());
	endtask

	initial begin
		checker_h = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_image(64'h0);
		send_image(64'hFFFF_FFFF_FFFF_FFFF);
		send_image(64'h1111_1111_1111_1111);
		send_image(64'h024);
		send_image(64'h014);
		send_image(64'h03);
		send_image(64'h05);
		send_image(64'h06);
		send_image(64'h073);
		send_image(64'h0A8);
		send_image(64'h70_0059);
		send_image(64'h70_005A);
		send_image(64'h0FB3);
		send_image(64'h0EC4);
		send_image(64'h0_334D);
		send_image(64'h033E);
		send_image(64'h00E3);
		send_image(64'h33_5F3);
		send_image(64'h00F);
		send_image(64'h8000_0000_0000_00FD);
		send_image(64'h9000_0000_0000_00FD);
		send_image(64'h3000_0000_0000_00FD);
		send_image(64'h0D);

		set_limit(16'd2);
		send_image(64'h03);
		send_image(64'h33);
		send_random(30);

		set_limit(16'd17);
		send_image(64'h3333_3333_3333_3333);
		send_random(30);

		set_limit(16'd65535);
		send_image(64'h0D);
		send_random(1);

		for (int phase = 0; phase < 5; phase++) begin
			set_limit(16'($urandom_range(200, 3)));
			if (phase == 2)
				hold_request = 1;
			send_random(40);
		end

		drain_runs();
		repeat (60) @(posedge clk);
		if (checker_h.mismatches == 0 && checker_h.pending_reports.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
